### design/gonm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gonm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_RADIUS_CELLS  = 2'd2,
    REG_OCC_THRESHOLD = 2'd3
  } cfg_reg_t;

  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int GRID_DIM_RST = 1024;
  localparam logic [6:0] THR_RST = 7'd40;

  // one input transaction
  typedef struct packed {
    logic signed [7:0] cell_value;
    logic              is_flush;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic signed [7:0] nearness_value;
    logic              is_last_cell;
  } out_item_t;

endpackage

`default_nettype wire

### design/grid_obstacle_nearness_map.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-----------------------------
// in_       | input     | in_valid / in_stall   | in_item_t  (cell, flush)
// out_      | output    | out_valid / out_stall | out_item_t (nearness, last)
// cfg_      | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One input cell per clock while in_stall is low. A result released by an input
// transaction passes through the column read, column distance and row window
// stages.
// in_stall rises when input runs RING - MAX_RADIUS - 1 rows ahead of the
// window read pointer, and from the grant of the last cell of a frame until
// that result is taken. out_stall freezes the result pipeline in place.
// Reset is synchronous, active low; line stores are not cleared.

module grid_obstacle_nearness_map
  import gonm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CB   = $clog2(MAX_WIDTH + 1);
  localparam int CA   = $clog2(MAX_WIDTH);
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int RING = 2 ** $clog2(4 * MAX_RADIUS + 4);
  localparam int SW   = $clog2(RING);
  localparam int RWID = (HB > SW) ? HB : SW;
  localparam int RWX  = RWID + 1;
  localparam int RB   = $clog2(MAX_RADIUS + 1);
  localparam int DB   = $clog2(MAX_RADIUS + 2);
  localparam int NW   = 2 * MAX_RADIUS + 1;
  localparam int JB   = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CBX  = ((CB > RB + 1) ? CB : RB + 1) + 1;
  localparam int LAG  = RING - MAX_RADIUS - 1;
  localparam int W_RST = (MAX_WIDTH < GRID_DIM_RST) ? MAX_WIDTH : GRID_DIM_RST;
  localparam int H_RST = (MAX_HEIGHT < GRID_DIM_RST) ? MAX_HEIGHT : GRID_DIM_RST;
  localparam logic [DB-1:0] D_NONE = DB'(MAX_RADIUS + 1);

  // effective configuration
  logic [CB-1:0] w_r;
  logic [HB-1:0] h_r;
  logic [RB-1:0] r_r;
  logic [6:0]    thr_r;

  // frame bookkeeping at transaction level
  logic [RWID-1:0] mi_row_r, g_row_r;
  logic [CB-1:0]   mi_col_r, g_col_r;
  logic            tail_r;

  // window read pointer
  logic [RWID-1:0] f_row_r;
  logic [JB-1:0]   f_j_r;

  // line stores
  logic [RING-1:0] occ_mem [MAX_WIDTH];
  logic [7:0]      cval_mem [RING * (2 ** CA)];
  logic [RING-1:0] occ_rd_r;
  logic [7:0]      cval_rd_r;

  // pipeline stages
  logic            s1_valid_r, s1_pad_r, s1_has_c_r, s1_last_r;
  logic [RWID-1:0] s1_row_r;
  logic [CB-1:0]   s1_ccol_r;
  logic [DB-1:0]   win_r [NW];
  logic                s2_valid_r, s2_last_r;
  logic [CB-1:0]       s2_ccol_r;
  logic signed [7:0]   s2_cval_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic in_acc, en;
  assign in_acc    = in_valid && !in_stall;
  assign en        = !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input side step
  logic            in_done, take, occ_bit, n_done, ready, g_last;
  logic [RWID-1:0] n_row;
  logic [CB-1:0]   n_col;
  logic [RWX-1:0]  need_r, h_m1;
  logic [CBX-1:0]  need_c, w_m1;

  always_comb begin
    h_m1    = RWX'(h_r) - RWX'(1);
    w_m1    = CBX'(w_r) - CBX'(1);
    in_done = RWX'(mi_row_r) >= RWX'(h_r);
    take    = !in_data.is_flush && !in_done;
    occ_bit = in_data.cell_value > $signed({1'b0, thr_r});
    n_row   = mi_row_r;
    n_col   = mi_col_r;
    if (take) begin
      if (CBX'(mi_col_r) == w_m1) begin
        n_col = '0;
        n_row = mi_row_r + RWID'(1);
      end else begin
        n_col = mi_col_r + CB'(1);
      end
    end
    n_done = RWX'(n_row) >= RWX'(h_r);
    need_r = RWX'(g_row_r) + RWX'(r_r);
    if (need_r > h_m1) need_r = h_m1;
    need_c = CBX'(g_col_r) + CBX'(r_r);
    if (need_c > w_m1) need_c = w_m1;
    ready  = n_done || (RWX'(n_row) > need_r) ||
             ((RWX'(n_row) == need_r) && (CBX'(n_col) > need_c));
    g_last = (RWX'(g_row_r) == h_m1) && (CBX'(g_col_r) == w_m1);
  end

  // input backpressure
  logic [RWX-1:0] lag;
  always_comb begin
    lag      = RWX'(mi_row_r) - RWX'(f_row_r);
    in_stall = tail_r ||
               ((mi_row_r > f_row_r) && (lag >= RWX'(LAG)));
  end

  // read pointer issue
  logic            f_active, f_real, f_has_c, data_ok, grant_ok, issue, f_wrap, f_last;
  logic [CB-1:0]   f_ccol;
  logic [RWX-1:0]  fneed_r;

  always_comb begin
    f_active = RWX'(f_row_r) < RWX'(h_r);
    f_real   = f_j_r < JB'(w_r);
    f_has_c  = f_j_r >= JB'(r_r);
    f_ccol   = CB'(f_j_r - JB'(r_r));
    fneed_r  = RWX'(f_row_r) + RWX'(r_r);
    if (fneed_r > h_m1) fneed_r = h_m1;
    data_ok  = tail_r || (RWX'(mi_row_r) > fneed_r) ||
               ((RWX'(mi_row_r) == fneed_r) && (JB'(mi_col_r) > f_j_r));
    grant_ok = !f_has_c || tail_r || (f_row_r < g_row_r) ||
               ((f_row_r == g_row_r) && (f_ccol < g_col_r));
    issue    = en && f_active && (!f_real || data_ok) && grant_ok;
    f_wrap   = f_j_r == (JB'(w_r) + JB'(r_r) - JB'(1));
    f_last   = (RWX'(f_row_r) == h_m1) && (CBX'(f_ccol) == w_m1);
  end

  // column distance to the nearest obstacle row
  logic [DB-1:0] vd;
  always_comb begin
    logic [SW-1:0] sp, sn;
    logic          pos_ok, neg_ok;
    vd = D_NONE;
    for (int d = MAX_RADIUS; d >= 0; d--) begin
      sp     = SW'(s1_row_r[SW-1:0] + SW'(d));
      sn     = SW'(s1_row_r[SW-1:0] - SW'(d));
      pos_ok = ((RWX'(s1_row_r) + RWX'(d)) < RWX'(h_r)) && occ_rd_r[sp];
      neg_ok = (RWX'(s1_row_r) >= RWX'(d)) && occ_rd_r[sn];
      if (!s1_pad_r && (RB'(d) <= r_r) && (pos_ok || neg_ok)) vd = DB'(d);
    end
  end

  // row window: chessboard distance and score
  logic signed [7:0] res_val;
  always_comb begin
    logic [RB:0]          adc;
    logic                 lo, inwin, colok;
    logic [MAX_RADIUS:0]  hit_d;
    logic                 found;
    logic [RB-1:0]        dd;
    logic [7:0]           score;
    hit_d = '0;
    for (int k = 0; k < NW; k++) begin
      lo    = (RB + 1)'(k) <= {1'b0, r_r};
      inwin = (RB + 1)'(k) <= ({1'b0, r_r} << 1);
      adc   = lo ? ({1'b0, r_r} - (RB + 1)'(k)) : ((RB + 1)'(k) - {1'b0, r_r});
      colok = lo ? ((CBX'(s2_ccol_r) + CBX'(adc)) < CBX'(w_r))
                 : (CBX'(s2_ccol_r) >= CBX'(adc));
      for (int dv = 0; dv <= MAX_RADIUS; dv++) begin
        if (inwin && colok && (adc <= (RB + 1)'(dv)) && (win_r[k] <= DB'(dv)) &&
            (RB'(dv) <= r_r)) hit_d[dv] = 1'b1;
      end
    end
    found = 1'b0;
    dd    = '0;
    for (int dv = MAX_RADIUS; dv >= 0; dv--) begin
      if (hit_d[dv]) begin
        found = 1'b1;
        dd    = RB'(dv);
      end
    end
    score   = 8'(r_r) - 8'(dd) + 8'd1;
    res_val = (found && ($signed(score) > s2_cval_r)) ? $signed(score) : s2_cval_r;
  end

  // line store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_acc && take && !cfg_wr_en) begin
      occ_mem[mi_col_r[CA-1:0]][mi_row_r[SW-1:0]] <= occ_bit;
      cval_mem[{mi_row_r[SW-1:0], mi_col_r[CA-1:0]}] <= in_data.cell_value;
    end
    if (en) begin
      occ_rd_r  <= occ_mem[f_j_r[CA-1:0]];
      cval_rd_r <= cval_mem[{f_row_r[SW-1:0], f_ccol[CA-1:0]}];
    end
  end

  // window shift and payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pad_r   <= !f_real;
      s1_has_c_r <= f_has_c;
      s1_last_r  <= f_last;
      s1_row_r   <= f_row_r;
      s1_ccol_r  <= f_ccol;
      if (s1_valid_r) begin
        win_r[0] <= vd;
        for (int k = 1; k < NW; k++) win_r[k] <= win_r[k-1];
      end
      s2_ccol_r <= s1_ccol_r;
      s2_cval_r <= $signed(cval_rd_r);
      s2_last_r <= s1_last_r;
      out_data_r.nearness_value <= res_val;
      out_data_r.is_last_cell   <= s2_last_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= CB'(W_RST);
      h_r         <= HB'(H_RST);
      r_r         <= '0;
      thr_r       <= THR_RST;
      mi_row_r    <= '0;
      mi_col_r    <= '0;
      g_row_r     <= '0;
      g_col_r     <= '0;
      tail_r      <= 1'b0;
      f_row_r     <= '0;
      f_j_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH: begin
          if (cfg_data == '0) w_r <= CB'(1);
          else if (32'(cfg_data) > 32'(MAX_WIDTH)) w_r <= CB'(MAX_WIDTH);
          else w_r <= CB'(cfg_data);
        end
        REG_GRID_HEIGHT: begin
          if (cfg_data == '0) h_r <= HB'(1);
          else if (32'(cfg_data) > 32'(MAX_HEIGHT)) h_r <= HB'(MAX_HEIGHT);
          else h_r <= HB'(cfg_data);
        end
        REG_RADIUS_CELLS: begin
          if (32'(cfg_data[3:0]) > 32'(MAX_RADIUS)) r_r <= RB'(MAX_RADIUS);
          else r_r <= RB'(cfg_data[3:0]);
        end
        REG_OCC_THRESHOLD: thr_r <= cfg_data[6:0];
        default: thr_r <= thr_r;
      endcase
      // restart the frame
      mi_row_r    <= '0;
      mi_col_r    <= '0;
      g_row_r     <= '0;
      g_col_r     <= '0;
      tail_r      <= 1'b0;
      f_row_r     <= '0;
      f_j_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // input transaction: advance cells and grant results
      if (in_acc) begin
        mi_row_r <= n_row;
        mi_col_r <= n_col;
        if (ready) begin
          if (g_last) begin
            mi_row_r <= '0;
            mi_col_r <= '0;
            g_row_r  <= '0;
            g_col_r  <= '0;
            tail_r   <= 1'b1;
          end else if (CBX'(g_col_r) == w_m1) begin
            g_col_r <= '0;
            g_row_r <= g_row_r + RWID'(1);
          end else begin
            g_col_r <= g_col_r + CB'(1);
          end
        end
      end
      // read pointer
      if (issue) begin
        if (f_wrap) begin
          f_j_r   <= '0;
          f_row_r <= f_row_r + RWID'(1);
        end else begin
          f_j_r <= f_j_r + JB'(1);
        end
      end
      // pipeline valids
      if (en) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r && s1_has_c_r;
        out_valid_r <= s2_valid_r;
      end
      // last result taken: frame fully drained
      if (out_valid_r && !out_stall && out_data_r.is_last_cell) begin
        tail_r  <= 1'b0;
        f_row_r <= '0;
        f_j_r   <= '0;
      end
    end
  end

  // drain flag holds until the last result leaves
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r && !cfg_wr_en && !(out_valid_r && !out_stall && out_data_r.is_last_cell))
      |=> tail_r)
    else $error("drain flag dropped early");

  // input never laps the line stores past the window read pointer
  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !tail_r |-> (RWX'(mi_row_r) <= (RWX'(f_row_r) + RWX'(LAG))))
    else $error("input ran too far ahead of window");

  // last cell only after the read pointer finished the frame
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_last_cell) |-> (RWX'(f_row_r) == RWX'(h_r)))
    else $error("last cell before frame read out");

endmodule

`default_nettype wire

### test/tb_grid_obstacle_nearness_map.sv
`timescale 1ns / 1ps

module tb_grid_obstacle_nearness_map;
  import gonm_pkg::*;

  localparam int MAX_W     = 1024;
  localparam int MAX_H     = 1024;
  localparam int MAX_R     = 8;
  localparam int RING      = 2 * MAX_R + 2;
  localparam int LATENCY   = 12;
  localparam int IDLE_LIMIT = 5000;

  // nearness map predictor and store of expected results
  class nearness_scoreboard;
    bit [0:0]         occ_line [RING][MAX_W];
    logic signed [7:0] val_line [RING][MAX_W];
    int unsigned cur_width, cur_height, cur_radius, cur_thresh;
    int unsigned take_row, take_col, give_row, give_col;
    out_item_t expected_q[$];
    bit frame_drained;
    int errors, cells_taken, results_seen, obstacles_seen;

    function void init();
      cur_width = GRID_DIM_RST;
      cur_height = GRID_DIM_RST;
      cur_radius = 0;
      cur_thresh = THR_RST;
      restart();
    endfunction

    function void restart();
      take_row = 0; take_col = 0; give_row = 0; give_col = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH:    cur_width = data;
        REG_GRID_HEIGHT:   cur_height = data;
        REG_RADIUS_CELLS:  cur_radius = data[3:0];
        REG_OCC_THRESHOLD: cur_thresh = data[6:0];
        default: ;
      endcase
      restart();
    endfunction

    // note an accepted input transaction, predict the result it releases
    function void note_input(in_item_t it);
      int unsigned w, h, r, need_r, need_c, slot;
      int best, rr, cc, ar, ac, d, score;
      bit done, last;
      out_item_t e;
      w = (cur_width == 0) ? 1 : ((cur_width > MAX_W) ? MAX_W : cur_width);
      h = (cur_height == 0) ? 1 : ((cur_height > MAX_H) ? MAX_H : cur_height);
      r = (cur_radius > MAX_R) ? MAX_R : cur_radius;
      done = take_row >= h;
      if (!it.is_flush && !done) begin
        slot = take_row % RING;
        val_line[slot][take_col] = it.cell_value;
        occ_line[slot][take_col] = (int'(it.cell_value) > int'(cur_thresh));
        if (occ_line[slot][take_col]) obstacles_seen++;
        cells_taken++;
        frame_drained = 0;
        take_col++;
        if (take_col >= w) begin
          take_col = 0;
          take_row++;
        end
        done = take_row >= h;
      end
      need_r = give_row + r;
      if (need_r > h - 1) need_r = h - 1;
      need_c = give_col + r;
      if (need_c > w - 1) need_c = w - 1;
      if (!(done || take_row > need_r || (take_row == need_r && take_col > need_c)))
        return;
      best = val_line[give_row % RING][give_col];
      for (int dr = -int'(r); dr <= int'(r); dr++) begin
        rr = int'(give_row) + dr;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int dc = -int'(r); dc <= int'(r); dc++) begin
          cc = int'(give_col) + dc;
          if (cc < 0 || cc >= int'(w)) continue;
          if (!occ_line[rr % RING][cc]) continue;
          ar = (dr < 0) ? -dr : dr;
          ac = (dc < 0) ? -dc : dc;
          d = (ar > ac) ? ar : ac;
          score = int'(r) - d + 1;
          if (score > best) best = score;
        end
      end
      last = (give_row == h - 1) && (give_col == w - 1);
      e.nearness_value = best[7:0];
      e.is_last_cell = last;
      expected_q.push_back(e);
      give_col++;
      if (give_col >= w) begin
        give_col = 0;
        give_row++;
      end
      if (last) begin
        restart();
        frame_drained = 1;
      end
    endfunction

    // compare an accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result nearness=%0d last=%0b", $time,
                 got.nearness_value, got.is_last_cell);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.nearness_value !== e.nearness_value) begin
        $display("%0t: nearness_value expected %0d actual %0d", $time,
                 e.nearness_value, got.nearness_value);
        errors++;
      end
      if (got.is_last_cell !== e.is_last_cell) begin
        $display("%0t: is_last_cell expected %0b actual %0b", $time,
                 e.is_last_cell, got.is_last_cell);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nearness_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int frames_run = 0;

  always #4 clk = ~clk;

  grid_obstacle_nearness_map i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, sb.expected_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern: none, light or heavy, switching now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 25);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // one input transaction, with bursts and gaps
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic in_item_t rand_cell();
    in_item_t it;
    it.is_flush = 1'b0;
    case ($urandom_range(0, 9))
      0: it.cell_value = 8'($urandom_range(0, 255));
      1: it.cell_value = -8'sd1;
      default: it.cell_value = 8'($urandom_range(0, 100));
    endcase
    return it;
  endfunction

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_grid(int w, int h, int r, int thr);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= REG_GRID_WIDTH; cfg_data <= CFG_DATA_W'(w);
    sb.write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT; cfg_data <= CFG_DATA_W'(h);
    sb.write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
    @(negedge clk);
    cfg_index <= REG_RADIUS_CELLS; cfg_data <= CFG_DATA_W'(r);
    sb.write_reg(REG_RADIUS_CELLS, CFG_DATA_W'(r));
    @(negedge clk);
    cfg_index <= REG_OCC_THRESHOLD; cfg_data <= CFG_DATA_W'(thr);
    sb.write_reg(REG_OCC_THRESHOLD, CFG_DATA_W'(thr));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // cells of a frame with some early flushes; drain to the last result if whole
  task automatic run_frame(int n_cells, bit whole, int flush_pct);
    in_item_t it;
    for (int i = 0; i < n_cells; i++) begin
      if ($urandom_range(0, 99) < flush_pct) begin
        it = rand_cell();
        it.is_flush = 1'b1;
        send(it);
      end
      send(rand_cell());
    end
    if (whole) begin
      while (!sb.frame_drained) begin
        it = rand_cell();
        it.is_flush = 1'b1;
        send(it);
      end
    end
    release_input();
    wait_idle();
    frames_run++;
  endtask

  int w, h;

  initial begin
    in_item_t it;
    sb.init();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extreme cell values in a small grid with a radius
    set_grid(4, 3, 1, 40);
    sb.frame_drained = 0;
    begin
      logic signed [7:0] vals [12];
      vals = '{8'sd127, -8'sd128, -8'sd1, 8'sd100, 8'sd0, 8'sd40, 8'sd41, 8'sd85,
               -8'sd86, 8'sd1, 8'sd99, 8'sd7};
      foreach (vals[k]) begin
        it.cell_value = vals[k];
        it.is_flush = 1'b0;
        send(it);
        if (k == 5) begin
          it.is_flush = 1'b1;
          send(it);
        end
      end
      while (!sb.frame_drained) begin
        it.cell_value = -8'sd1;
        it.is_flush = 1'b1;
        send(it);
      end
      release_input();
      wait_idle();
    end

    // register extremes: zero and oversize dimensions, radius 0 and clamped
    set_grid(0, 3, 0, 0);
    sb.frame_drained = 0;
    run_frame(3, 1, 10);
    set_grid(2047, 1, 15, 127);
    sb.frame_drained = 0;
    run_frame(150, 0, 0);
    set_grid(1, 1024, 8, 100);
    sb.frame_drained = 0;
    run_frame(100, 0, 0);

    // an unfinished frame, cut short by a register write
    set_grid(10, 10, 3, 50);
    sb.frame_drained = 0;
    run_frame(37, 0, 5);

    // random grids, mostly small
    for (int p = 0; p < 8; p++) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      set_grid(w, h, $urandom_range(0, 15), $urandom_range(0, 127));
      sb.frame_drained = 0;
      if ($urandom_range(0, 7) == 0) run_frame($urandom_range(1, w * h), 0, 8);
      else run_frame(w * h, 1, $urandom_range(0, 15));
    end

    wait_idle();
    $display("%0d frames, %0d cells taken (%0d obstacles), %0d results checked",
             frames_run, sb.cells_taken, sb.obstacles_seen, sb.results_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/gonm_pkg.sv
design/grid_obstacle_nearness_map.sv
test/tb_grid_obstacle_nearness_map.sv
